// ----- src/hwls_pkg.sv -----
// Shared types and helpers for the hazard wave level scheduler.
// No dependencies.
package hwls_pkg;

  localparam int ADDR_W = 64;
  localparam int WAVE_W = 8;
  localparam int IDX_W  = 8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_BATCH = 2'd3
  } cmd_t;

  // Wave of a dependent operation, saturating.
  function automatic logic [WAVE_W-1:0] wave_inc(input logic [WAVE_W-1:0] w);
    wave_inc = (w == {WAVE_W{1'b1}}) ? w : w + 1'b1;
  endfunction

endpackage

// ----- src/hwls_if.sv -----
// Valid/ready channels of the scheduler: reference words in, results out.
// Depends on hwls_pkg.
interface hwls_req_if;
  logic                           valid;
  logic                           ready;
  hwls_pkg::cmd_t                 cmd;
  logic [hwls_pkg::ADDR_W-1:0]    addr;
  logic                           last_ref;
  modport source (output valid, cmd, addr, last_ref, input ready);
  modport sink   (input valid, cmd, addr, last_ref, output ready);
endinterface

interface hwls_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [hwls_pkg::IDX_W-1:0]     op_index;
  logic [hwls_pkg::WAVE_W-1:0]    wave;
  logic                           table_full;
  logic                           refs_overflow;
  logic                           op_overflow;
  modport source (output valid, op_index, wave, table_full, refs_overflow, op_overflow,
                  input ready);
  modport sink   (input valid, op_index, wave, table_full, refs_overflow, op_overflow,
                  output ready);
endinterface

// ----- src/hazard_wave_level_scheduler.sv -----
// Hazard wave level scheduler top level.
// Depends on hwls_pkg and the channel interfaces in hwls_if.
//
// A read or write reference is taken in S_IDLE while the address is matched
// against the tag registers and the wave memories are read, and the
// dependence is folded in on the next cycle, in S_DEP. A finishing operation
// then walks its buffered references twice (reads, then writes) through the
// single read port of the wave memories: each buffered read visits S_FRD and
// then S_FWR, each buffered write and each skipped entry visits S_FRD only,
// each pass ends in S_FRD, and the result is loaded in S_DONE, later while
// the output register is still held. A batch clear is done in S_IDLE as the
// command is taken; the tracking table is cleared by its valid bits, with no
// clearing pass. A finished result waits in an output register while the
// next word is taken.
module hazard_wave_level_scheduler #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MAX_REFS      = 8,
  parameter int MAX_OPS       = 256
) (
  input  logic        clk,
  input  logic        rst,
  hwls_req_if.sink    req,
  hwls_rsp_if.source  rsp
);

  localparam int SW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(MAX_REFS + 1);
  localparam int PW  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int OCW = $clog2(MAX_OPS + 1);
  localparam int AW  = hwls_pkg::ADDR_W;
  localparam int WW  = hwls_pkg::WAVE_W;

  typedef enum logic [2:0] {S_IDLE, S_DEP, S_FRD, S_FWR, S_DONE} state_t;

  state_t state;

  logic [AW-1:0] tag [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid, has_writer, has_readers;
  logic [WW-1:0] wmem [TABLE_ENTRIES];
  logic [WW-1:0] rmem [TABLE_ENTRIES];
  logic [WW-1:0] wrd, rrd;

  logic [AW-1:0] pend_addr [MAX_REFS];
  logic          pend_wr   [MAX_REFS];
  logic [CW-1:0] pcount;
  logic [WW-1:0] rwave;
  logic [OCW-1:0] opcnt;
  logic          flag_full, flag_refs;

  logic          dep_hit, dep_wr, dep_last;
  logic [SW-1:0] dep_slot;
  logic          fin_pass;
  logic [CW-1:0] fin_i;
  logic [SW-1:0] fin_slot;

  logic          out_valid;
  logic [hwls_pkg::IDX_W-1:0] out_index;
  logic [WW-1:0] out_wave;
  logic          out_full, out_refs, out_ovf;

  // Tag match and free-slot search
  logic [AW-1:0] cam_key, cur_addr;
  logic          cur_wr;
  logic          cam_hit, free_ok;
  logic [SW-1:0] cam_idx, free_idx, fin_sel, rd_idx;
  logic [PW-1:0] cur_pi;

  assign cur_pi   = fin_i[PW-1:0];
  assign cur_addr = pend_addr[cur_pi];
  assign cur_wr   = pend_wr[cur_pi];
  assign cam_key  = (state == S_FRD) ? cur_addr : req.addr;

  always_comb begin
    cam_hit  = 1'b0;
    cam_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && tag[i] == cam_key) begin
        cam_hit = 1'b1;
        cam_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign fin_sel = cam_hit ? cam_idx : free_idx;
  assign rd_idx  = (state == S_FRD) ? fin_sel : cam_idx;

  logic accept, fin_active, fin_end, fin_skip, fin_none;
  assign accept     = req.valid && req.ready;
  assign fin_end    = fin_i >= pcount;
  assign fin_skip   = !fin_end && (cur_wr != fin_pass);
  assign fin_none   = !cam_hit && !free_ok;
  assign fin_active = (state == S_FRD) && !fin_end && !fin_skip && !fin_none;

  // Dependence fold
  logic [WW-1:0] dep_w1, dep_w2, dep_wave;
  always_comb begin
    dep_w1 = hwls_pkg::wave_inc(wrd);
    dep_w2 = hwls_pkg::wave_inc(rrd);
    dep_wave = rwave;
    if (dep_hit && has_writer[dep_slot] && dep_w1 > dep_wave) dep_wave = dep_w1;
    if (dep_hit && dep_wr && has_readers[dep_slot] && dep_w2 > dep_wave) dep_wave = dep_w2;
  end

  logic ops_ovf;
  logic [31:0] idx_ext;
  assign ops_ovf = opcnt == OCW'(MAX_OPS);
  assign idx_ext = ops_ovf ? 32'(MAX_OPS - 1) : 32'(opcnt);

  // Wave memories: one read and one write a cycle, read data registered
  always_ff @(posedge clk) begin
    wrd <= wmem[rd_idx];
    rrd <= rmem[rd_idx];
    if (fin_active && fin_pass) wmem[fin_sel] <= rwave;
    if (state == S_FWR && (!has_readers[fin_slot] || rwave > rrd)) rmem[fin_slot] <= rwave;
  end

  // Tags and pending buffer hold payload only
  always_ff @(posedge clk) begin
    if (fin_active && !cam_hit) tag[fin_sel] <= cur_addr;
    if (state == S_IDLE && accept && (req.cmd == hwls_pkg::CMD_READ ||
        req.cmd == hwls_pkg::CMD_WRITE) && pcount < CW'(MAX_REFS)) begin
      pend_addr[pcount[PW-1:0]] <= req.addr;
      pend_wr[pcount[PW-1:0]]   <= req.cmd == hwls_pkg::CMD_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      has_writer  <= '0;
      has_readers <= '0;
      pcount      <= '0;
      rwave       <= '0;
      opcnt       <= '0;
      flag_full   <= 1'b0;
      flag_refs   <= 1'b0;
      out_valid   <= 1'b0;
      fin_pass    <= 1'b0;
      fin_i       <= '0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fin_pass <= 1'b0;
            fin_i    <= '0;
            unique case (req.cmd)
              hwls_pkg::CMD_BATCH: begin
                slot_valid  <= '0;
                has_writer  <= '0;
                has_readers <= '0;
                opcnt       <= '0;
                pcount      <= '0;
                rwave       <= '0;
                flag_full   <= 1'b0;
                flag_refs   <= 1'b0;
              end
              hwls_pkg::CMD_MARK: state <= S_FRD;
              hwls_pkg::CMD_READ, hwls_pkg::CMD_WRITE: begin
                if (pcount < CW'(MAX_REFS)) begin
                  pcount   <= pcount + 1'b1;
                  dep_hit  <= cam_hit;
                  dep_slot <= cam_idx;
                  dep_wr   <= req.cmd == hwls_pkg::CMD_WRITE;
                  dep_last <= req.last_ref;
                  state    <= S_DEP;
                end else begin
                  flag_refs <= 1'b1;
                  if (req.last_ref) state <= S_FRD;
                end
              end
            endcase
          end
        end
        S_DEP: begin
          rwave <= dep_wave;
          state <= dep_last ? S_FRD : S_IDLE;
        end
        S_FRD: begin
          if (fin_end) begin
            fin_i <= '0;
            if (!fin_pass) fin_pass <= 1'b1;
            else state <= S_DONE;
          end else if (fin_skip) begin
            fin_i <= fin_i + 1'b1;
          end else if (fin_none) begin
            flag_full <= 1'b1;
            fin_i     <= fin_i + 1'b1;
          end else begin
            if (!cam_hit) slot_valid[fin_sel] <= 1'b1;
            if (fin_pass) begin
              has_writer[fin_sel]  <= 1'b1;
              has_readers[fin_sel] <= 1'b0;
              fin_i <= fin_i + 1'b1;
            end else begin
              // fresh slot starts with no writer and no readers
              if (!cam_hit) begin
                has_writer[fin_sel]  <= 1'b0;
                has_readers[fin_sel] <= 1'b0;
              end
              fin_slot <= fin_sel;
              state    <= S_FWR;
            end
          end
        end
        S_FWR: begin
          has_readers[fin_slot] <= 1'b1;
          fin_i <= fin_i + 1'b1;
          state <= S_FRD;
        end
        S_DONE: begin
          // load the result once the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_index <= idx_ext[hwls_pkg::IDX_W-1:0];
            out_wave  <= rwave;
            out_full  <= flag_full;
            out_refs  <= flag_refs;
            out_ovf   <= ops_ovf;
            if (!ops_ovf) opcnt <= opcnt + 1'b1;
            pcount    <= '0;
            rwave     <= '0;
            flag_full <= 1'b0;
            flag_refs <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = state == S_IDLE;
  assign rsp.valid         = out_valid;
  assign rsp.op_index      = out_index;
  assign rsp.wave          = out_wave;
  assign rsp.table_full    = out_full;
  assign rsp.refs_overflow = out_refs;
  assign rsp.op_overflow   = out_ovf;

endmodule

// ----- src/hwls_check.sv -----
// Port-level assertions for the hazard wave level scheduler, bound to the top.
// Depends on hwls_pkg and hazard_wave_level_scheduler.
module hwls_check #(
  parameter int MAX_OPS = 256
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input hwls_pkg::cmd_t       req_cmd,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [7:0]           rsp_op_index,
  input logic                 rsp_op_overflow
);

  localparam logic [31:0] LastIdx = 32'(MAX_OPS - 1);

  // hold a result until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before taken");

  // a marker always starts a finish, so the block is busy next cycle
  a_mark_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == hwls_pkg::CMD_MARK |=> !req_ready)
    else $error("ready right after operation marker");

  // no result appears the cycle after a word is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after a word");

  // saturated index on overflow
  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_op_overflow |-> rsp_op_index == LastIdx[7:0])
    else $error("op index not saturated on overflow");

endmodule

bind hazard_wave_level_scheduler hwls_check #(.MAX_OPS(MAX_OPS)) u_hwls_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_cmd         (req.cmd),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_op_index    (rsp.op_index),
  .rsp_op_overflow (rsp.op_overflow)
);
